// ===== src/tfa_pkg.sv =====
// Package for the tagged fixnum ALU: widths, operation codes, cell bus type.
// No dependencies. Imported by every module of the block.
`default_nettype none
package tfa_pkg;
    localparam int TAG_BITS  = 3;
    localparam int DATA_W    = 64;
    localparam int PAY_W     = DATA_W - TAG_BITS;
    localparam int NUM_CELLS = PAY_W;
    localparam int CMD_W     = 3;
    localparam int S_FIELDS_W = CMD_W + 2 * DATA_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DATA_W + 1 + 7) / 8) * 8;
    // Tag placed in the low bits of every result word.
    localparam logic [TAG_BITS-1:0] INT_TAG = TAG_BITS'(1);

    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_OR   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_AND  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_ASH  = 3'd6;
    // Unused code; it yields a zero payload.
    localparam logic [CMD_W-1:0] CMD_RSVD = 3'd7;

    // What the cells do with a beat.
    localparam logic [1:0] KIND_PASS = 2'd0;
    localparam logic [1:0] KIND_MUL  = 2'd1;
    localparam logic [1:0] KIND_DIV  = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [1:0]       kind;
        logic             neg;
        logic             dz;
        logic [PAY_W-1:0] x;   // accumulator, remainder or finished result
        logic [PAY_W-1:0] y;   // multiplier or dividend/quotient
        logic [PAY_W-1:0] z;   // multiplicand or divisor
    } t_cell_bus;
endpackage
`default_nettype wire

// ===== src/tfa_front.sv =====
// Input stage: untags operands and computes the operations that need no cell steps.
// Depends on tfa_pkg. Feeds the first cell of the chain.
`default_nettype none
module tfa_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [tfa_pkg::CMD_W-1:0] i_cmd,
    input  wire logic [tfa_pkg::DATA_W-1:0] i_a,
    input  wire logic [tfa_pkg::DATA_W-1:0] i_b,
    output tfa_pkg::t_cell_bus             o_bus
);
    import tfa_pkg::*;

    logic [PAY_W-1:0]  a_pay, b_pay, a_mag, b_mag, cnt_mag;
    logic [DATA_W-1:0] a_ext;
    logic              big;
    logic [PAY_W-1:0]  shl_res, asr_res;
    t_cell_bus         n_bus, r_bus;

    // Untag, magnitudes and the barrel shift.
    always_comb begin
        a_pay   = i_a[DATA_W-1:TAG_BITS];
        b_pay   = i_b[DATA_W-1:TAG_BITS];
        a_mag   = a_pay[PAY_W-1] ? (~a_pay + PAY_W'(1)) : a_pay;
        b_mag   = b_pay[PAY_W-1] ? (~b_pay + PAY_W'(1)) : b_pay;
        cnt_mag = ~b_pay + PAY_W'(1);
        a_ext   = {{TAG_BITS{a_pay[PAY_W-1]}}, a_pay};
        big     = b_pay[PAY_W-1] ? (|cnt_mag[PAY_W-1:6]) : (|b_pay[PAY_W-1:6]);
        shl_res = big ? '0 : PAY_W'(a_ext << b_pay[5:0]);
        asr_res = big ? {PAY_W{a_pay[PAY_W-1]}}
                      : PAY_W'($signed(a_ext) >>> cnt_mag[5:0]);
    end

    // Load the first cell bus.
    always_comb begin
        n_bus       = '0;
        n_bus.valid = i_valid;
        case (i_cmd)
            CMD_ADD: n_bus.x = a_pay + b_pay;
            CMD_SUB: n_bus.x = a_pay - b_pay;
            CMD_MUL: begin
                n_bus.kind = KIND_MUL;
                n_bus.y    = b_pay;
                n_bus.z    = a_pay;
            end
            CMD_DIV: begin
                n_bus.kind = KIND_DIV;
                n_bus.neg  = a_pay[PAY_W-1] ^ b_pay[PAY_W-1];
                n_bus.dz   = (b_pay == '0);
                n_bus.y    = a_mag;
                n_bus.z    = b_mag;
            end
            CMD_OR:  n_bus.x = a_pay | b_pay;
            CMD_AND: n_bus.x = a_pay & b_pay;
            CMD_ASH: n_bus.x = b_pay[PAY_W-1] ? asr_res : shl_res;
            default: n_bus.x = '0;
        endcase
    end

    // Stage register; reset clears the whole bus, valid bit included.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus <= '0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;
endmodule
`default_nettype wire

// ===== src/tfa_cell.sv =====
// One cell of the chain: one shift-add multiply step, one restoring divide step, or a pass.
// Depends on tfa_pkg. Instantiated NUM_CELLS times by the top level.
`default_nettype none
module tfa_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  tfa_pkg::t_cell_bus i_bus,
    output tfa_pkg::t_cell_bus o_bus
);
    import tfa_pkg::*;

    logic [PAY_W-1:0] trial;
    logic [PAY_W:0]   diff;
    logic             ge;
    t_cell_bus        n_bus, r_bus;

    // One step on the beat held by the previous stage.
    always_comb begin
        n_bus = i_bus;
        trial = {i_bus.x[PAY_W-2:0], i_bus.y[PAY_W-1]};
        diff  = {1'b0, trial} - {1'b0, i_bus.z};
        ge    = ~diff[PAY_W];
        case (i_bus.kind)
            KIND_MUL: begin
                n_bus.x = i_bus.x + (i_bus.y[0] ? i_bus.z : '0);
                n_bus.y = i_bus.y >> 1;
                n_bus.z = i_bus.z << 1;
            end
            KIND_DIV: begin
                n_bus.x = ge ? diff[PAY_W-1:0] : trial;
                n_bus.y = {i_bus.y[PAY_W-2:0], ge};
            end
            default: n_bus = i_bus;
        endcase
    end

    // Cell register; reset clears the whole bus, valid bit included.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus <= '0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;
endmodule
`default_nettype wire

// ===== src/tagged_fixnum_alu_unit.sv =====
// Top level of the tagged fixnum ALU: input stage, cell chain, output register.
// Depends on tfa_pkg, tfa_front and tfa_cell.
//
//  channel  dir  tdata fields (low bit up)
//  s_axis   in   cmd[2:0], operand_a[66:3], operand_b[130:67], zero pad
//  m_axis   out  tagged_result[63:0], divide_by_zero[64], zero pad
//
// One beat per cycle is accepted while the pipeline is not held; each result passes through
// one input stage, one cell per payload bit (used by multiply and divide) and one output stage.
// The whole pipeline advances together; it holds when the output register is full
// and not taken, and the input then sees tready low.
// Reset clears the valid bits of every stage.
`default_nettype none
module tagged_fixnum_alu_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // cmd, operand_a, operand_b, zero pad
    input  wire logic [tfa_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // tagged_result, divide_by_zero, zero pad
    output logic [tfa_pkg::M_TDATA_W-1:0]      o_m_axis_tdata
);
    import tfa_pkg::*;

    logic             en;
    t_cell_bus        chain [NUM_CELLS+1];
    t_cell_bus        last;
    logic [PAY_W-1:0] n_res, r_res;
    logic             n_dz, r_dz, r_out_valid;

    assign en              = ~r_out_valid | i_m_axis_tready;
    assign o_s_axis_tready = en;

    tfa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_cmd   (i_s_axis_tdata[CMD_W-1:0]),
        .i_a     (i_s_axis_tdata[CMD_W+DATA_W-1:CMD_W]),
        .i_b     (i_s_axis_tdata[CMD_W+2*DATA_W-1:CMD_W+DATA_W]),
        .o_bus   (chain[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        tfa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bus   (chain[g]),
            .o_bus   (chain[g+1])
        );
    end

    assign last = chain[NUM_CELLS];

    // Quotient sign and divide-by-zero fixup.
    always_comb begin
        n_dz  = 1'b0;
        n_res = last.x;
        if (last.kind == KIND_DIV) begin
            n_dz  = last.dz;
            n_res = last.dz ? '0 : (last.neg ? (~last.y + PAY_W'(1)) : last.y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
            r_dz  <= n_dz;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W-DATA_W-1){1'b0}}, r_dz, r_res, INT_TAG};
endmodule
`default_nettype wire
